@@ rtl/mfqs_pkg.sv @@
// Shared types, widths and codes for the multilevel feedback queue scheduler.
package mfqs_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 32;
  localparam int DEFAULT_LEVELS      = 3;
  localparam int CMDQ_DEPTH          = 2;

  localparam int ID_W     = 8;
  localparam int TICK_W   = 16;
  localparam int LVL_W    = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int ENTRY_W  = ID_W + TICK_W;

  localparam logic [TICK_W-1:0] RESET_QUANTUM_TOP    = 16'd5;
  localparam logic [TICK_W-1:0] RESET_QUANTUM_MIDDLE = 16'd10;
  localparam logic [TICK_W-1:0] RESET_QUANTUM_BOTTOM = 16'd15;

  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_TOP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_MIDDLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_BOTTOM = 2'd2;

  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic              is_dispatch;
    logic [ID_W-1:0]   proc_id;
    logic [TICK_W-1:0] burst_time;
    logic [LVL_W-1:0]  level;
  } cmd_t;

endpackage

@@ rtl/multilevel_feedback_queue_scheduler.sv @@
// Top level of the multilevel feedback queue scheduler: front end, command queue, back end.
// An add word is written to its level queue when the back end pops it; a dispatch word reads
// memory, then slices and writes back to the target level in a serve state, during which no
// further command is popped; busy rises when the command queue is full.
// Reset: all level queues empty, quanta 5/10/15; queue memory contents are not cleared.
// Results carry a one-cycle done strobe; the receiver cannot stall.
module multilevel_feedback_queue_scheduler #(
  parameter int QUEUE_DEPTH = mfqs_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int LEVELS      = mfqs_pkg::DEFAULT_LEVELS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           operation,
  input  logic [mfqs_pkg::ID_W-1:0]      proc_id,
  input  logic [mfqs_pkg::TICK_W-1:0]    burst_time,
  input  logic [mfqs_pkg::LVL_W-1:0]     add_level,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mfqs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mfqs_pkg::TICK_W-1:0]    cfg_data,
  output logic                           done,
  output logic [mfqs_pkg::STATUS_W-1:0]  status,
  output logic [mfqs_pkg::LVL_W-1:0]     served_level,
  output logic [mfqs_pkg::ID_W-1:0]      served_id,
  output logic [mfqs_pkg::TICK_W-1:0]    ran_ticks,
  output logic [mfqs_pkg::TICK_W-1:0]    left_ticks,
  output logic                           finished,
  output logic [mfqs_pkg::LVL_W-1:0]     target_level,
  output logic                           demote_dropped
);

  logic           cmd_valid;
  logic           cmd_pop;
  mfqs_pkg::cmd_t cmd;

  mfqs_front #(
    .LEVELS(LEVELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .proc_id    (proc_id),
    .burst_time (burst_time),
    .add_level  (add_level),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  mfqs_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .LEVELS     (LEVELS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .status         (status),
    .served_level   (served_level),
    .served_id      (served_id),
    .ran_ticks      (ran_ticks),
    .left_ticks     (left_ticks),
    .finished       (finished),
    .target_level   (target_level),
    .demote_dropped (demote_dropped)
  );

endmodule

@@ rtl/mfqs_front.sv @@
// Command front end: accepts and classifies words into a short command queue.
module mfqs_front #(
  parameter int LEVELS = mfqs_pkg::DEFAULT_LEVELS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        operation,
  input  logic [mfqs_pkg::ID_W-1:0]   proc_id,
  input  logic [mfqs_pkg::TICK_W-1:0] burst_time,
  input  logic [mfqs_pkg::LVL_W-1:0]  add_level,
  output logic                        cmd_valid,
  output mfqs_pkg::cmd_t              cmd,
  input  logic                        cmd_pop
);

  localparam int QP_W = $clog2(mfqs_pkg::CMDQ_DEPTH);
  localparam int QC_W = $clog2(mfqs_pkg::CMDQ_DEPTH + 1);

  mfqs_pkg::cmd_t             entries [mfqs_pkg::CMDQ_DEPTH];
  logic [QP_W-1:0]            wr_ptr;
  logic [QP_W-1:0]            rd_ptr;
  logic [QC_W-1:0]            fill;
  logic                       push;
  mfqs_pkg::cmd_t             incoming;

  assign busy      = (fill == QC_W'(mfqs_pkg::CMDQ_DEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (fill != '0);
  assign cmd       = entries[rd_ptr];

  // clamp out-of-range levels to the bottom level
  always_comb begin
    incoming.is_dispatch = (operation == mfqs_pkg::OP_DISPATCH);
    incoming.proc_id     = proc_id;
    incoming.burst_time  = burst_time;
    if (add_level >= mfqs_pkg::LVL_W'(LEVELS)) begin
      incoming.level = mfqs_pkg::LVL_W'(LEVELS - 1);
    end else begin
      incoming.level = add_level;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QP_W'(mfqs_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= (rd_ptr == QP_W'(mfqs_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !cmd_pop) begin
        fill <= fill + 1'b1;
      end else if (!push && cmd_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ rtl/mfqs_back.sv @@
// Execution back end: level queues in memory, dispatch, slice and requeue.
module mfqs_back #(
  parameter int QUEUE_DEPTH = mfqs_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int LEVELS      = mfqs_pkg::DEFAULT_LEVELS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  mfqs_pkg::cmd_t                 cmd,
  output logic                           cmd_pop,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mfqs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mfqs_pkg::TICK_W-1:0]    cfg_data,
  output logic                           done,
  output logic [mfqs_pkg::STATUS_W-1:0]  status,
  output logic [mfqs_pkg::LVL_W-1:0]     served_level,
  output logic [mfqs_pkg::ID_W-1:0]      served_id,
  output logic [mfqs_pkg::TICK_W-1:0]    ran_ticks,
  output logic [mfqs_pkg::TICK_W-1:0]    left_ticks,
  output logic                           finished,
  output logic [mfqs_pkg::LVL_W-1:0]     target_level,
  output logic                           demote_dropped
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int LI_W   = $clog2(LEVELS);
  localparam int ADDR_W = $clog2(LEVELS * QUEUE_DEPTH);
  localparam int MEM_DEPTH = LEVELS * QUEUE_DEPTH;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SERVE = 1'b1;

  logic [mfqs_pkg::ENTRY_W-1:0] mem [MEM_DEPTH];
  logic [mfqs_pkg::ENTRY_W-1:0] rd_data;

  logic [PTR_W-1:0] head  [LEVELS];
  logic [PTR_W-1:0] tail  [LEVELS];
  logic [CNT_W-1:0] count [LEVELS];

  logic                        state;
  logic [LI_W-1:0]             cur_level;
  logic [mfqs_pkg::TICK_W-1:0] quantum_top;
  logic [mfqs_pkg::TICK_W-1:0] quantum_middle;
  logic [mfqs_pkg::TICK_W-1:0] quantum_bottom;

  logic [LI_W-1:0]              add_idx;
  logic                         add_full;
  logic                         found;
  logic [LI_W-1:0]              sel;
  logic [mfqs_pkg::TICK_W-1:0]  rem;
  logic [mfqs_pkg::TICK_W-1:0]  quantum;
  logic [mfqs_pkg::TICK_W-1:0]  ran;
  logic [mfqs_pkg::TICK_W-1:0]  left;
  logic                         is_done;
  logic [LI_W-1:0]              tgt;
  logic                         tgt_full;
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_waddr;
  logic [mfqs_pkg::ENTRY_W-1:0] mem_wdata;
  logic                         mem_re;
  logic [ADDR_W-1:0]            mem_raddr;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [LI_W-1:0] l,
                                                input logic [PTR_W-1:0] p);
    addr_of = ADDR_W'(l) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
  endfunction

  assign cfg_ready = 1'b1;
  assign cmd_pop   = (state == ST_IDLE) && cmd_valid;

  assign add_idx  = cmd.level[LI_W-1:0];
  assign add_full = (count[add_idx] == CNT_W'(QUEUE_DEPTH));

  // lowest-numbered (top) non-empty level wins
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        found = 1'b1;
        sel   = LI_W'(i);
      end
    end
  end

  always_comb begin
    rem = rd_data[mfqs_pkg::TICK_W-1:0];
    if (cur_level == LI_W'(LEVELS - 1)) begin
      quantum = quantum_bottom;
    end else if (cur_level == '0) begin
      quantum = quantum_top;
    end else begin
      quantum = quantum_middle;
    end
    if (quantum == '0 || rem <= quantum) begin
      ran  = rem;
      left = '0;
    end else begin
      ran  = quantum;
      left = rem - quantum;
    end
    is_done  = (left == '0);
    tgt      = (cur_level == LI_W'(LEVELS - 1)) ? cur_level : cur_level + 1'b1;
    tgt_full = (count[tgt] == CNT_W'(QUEUE_DEPTH));
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_of(add_idx, tail[add_idx]);
    mem_wdata = {cmd.proc_id, cmd.burst_time};
    mem_re    = 1'b0;
    mem_raddr = addr_of(sel, head[sel]);
    if (state == ST_IDLE) begin
      if (cmd_pop && !cmd.is_dispatch && !add_full) begin
        mem_we = 1'b1;
      end
      if (cmd_pop && cmd.is_dispatch && found) begin
        mem_re = 1'b1;
      end
    end else if (!is_done && !tgt_full) begin
      mem_we    = 1'b1;
      mem_waddr = addr_of(tgt, tail[tgt]);
      mem_wdata = {rd_data[mfqs_pkg::ENTRY_W-1:mfqs_pkg::TICK_W], left};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_top    <= mfqs_pkg::RESET_QUANTUM_TOP;
      quantum_middle <= mfqs_pkg::RESET_QUANTUM_MIDDLE;
      quantum_bottom <= mfqs_pkg::RESET_QUANTUM_BOTTOM;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mfqs_pkg::CFG_QUANTUM_TOP:    quantum_top    <= cfg_data;
        mfqs_pkg::CFG_QUANTUM_MIDDLE: quantum_middle <= cfg_data;
        mfqs_pkg::CFG_QUANTUM_BOTTOM: quantum_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_level <= '0;
      done      <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            served_level   <= '0;
            served_id      <= '0;
            ran_ticks      <= '0;
            left_ticks     <= '0;
            finished       <= 1'b0;
            target_level   <= '0;
            demote_dropped <= 1'b0;
            if (!cmd.is_dispatch) begin
              done <= 1'b1;
              if (add_full) begin
                status <= mfqs_pkg::STATUS_FULL;
              end else begin
                status         <= mfqs_pkg::STATUS_OK;
                tail[add_idx]  <= ptr_inc(tail[add_idx]);
                count[add_idx] <= count[add_idx] + 1'b1;
              end
            end else if (!found) begin
              done   <= 1'b1;
              status <= mfqs_pkg::STATUS_EMPTY;
            end else begin
              head[sel]  <= ptr_inc(head[sel]);
              count[sel] <= count[sel] - 1'b1;
              cur_level  <= sel;
              state      <= ST_SERVE;
            end
          end
        end
        ST_SERVE: begin
          done           <= 1'b1;
          status         <= mfqs_pkg::STATUS_OK;
          served_level   <= mfqs_pkg::LVL_W'(cur_level);
          served_id      <= rd_data[mfqs_pkg::ENTRY_W-1:mfqs_pkg::TICK_W];
          ran_ticks      <= ran;
          left_ticks     <= left;
          finished       <= is_done;
          target_level   <= is_done ? '0 : mfqs_pkg::LVL_W'(tgt);
          demote_dropped <= !is_done && tgt_full;
          if (!is_done && !tgt_full) begin
            tail[tgt]  <= ptr_inc(tail[tgt]);
            count[tgt] <= count[tgt] + 1'b1;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ sim/tb_multilevel_feedback_queue_scheduler.sv @@
`timescale 1ns / 100ps
// Self-checking testbench: random and directed scheduler words against a shadow queue model.
module tb_multilevel_feedback_queue_scheduler;

  localparam int ID_W      = mfqs_pkg::ID_W;
  localparam int TICK_W    = mfqs_pkg::TICK_W;
  localparam int LVL_W     = mfqs_pkg::LVL_W;
  localparam int STATUS_W  = mfqs_pkg::STATUS_W;
  localparam int CFG_IDX_W = mfqs_pkg::CFG_IDX_W;
  localparam int ENTRY_W   = mfqs_pkg::ENTRY_W;

  localparam logic [TICK_W-1:0] RESET_QUANTUM_TOP    = mfqs_pkg::RESET_QUANTUM_TOP;
  localparam logic [TICK_W-1:0] RESET_QUANTUM_MIDDLE = mfqs_pkg::RESET_QUANTUM_MIDDLE;
  localparam logic [TICK_W-1:0] RESET_QUANTUM_BOTTOM = mfqs_pkg::RESET_QUANTUM_BOTTOM;

  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_TOP    = mfqs_pkg::CFG_QUANTUM_TOP;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_MIDDLE = mfqs_pkg::CFG_QUANTUM_MIDDLE;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_BOTTOM = mfqs_pkg::CFG_QUANTUM_BOTTOM;

  localparam logic OP_ADD      = mfqs_pkg::OP_ADD;
  localparam logic OP_DISPATCH = mfqs_pkg::OP_DISPATCH;

  localparam logic [STATUS_W-1:0] STATUS_FULL  = mfqs_pkg::STATUS_FULL;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = mfqs_pkg::STATUS_EMPTY;

  typedef mfqs_pkg::cmd_t cmd_t;

  localparam int DEPTH = mfqs_pkg::DEFAULT_QUEUE_DEPTH;
  localparam int NLVL = mfqs_pkg::DEFAULT_LEVELS;
  localparam int IDLE_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 130;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LVL_W-1:0]    served_level;
    logic [ID_W-1:0]     served_id;
    logic [TICK_W-1:0]   ran_ticks;
    logic [TICK_W-1:0]   left_ticks;
    logic                finished;
    logic [LVL_W-1:0]    target_level;
    logic                demote_dropped;
  } outcome_t;

  class sched_shadow;
    logic [ENTRY_W-1:0] slot [NLVL][DEPTH];
    int unsigned head [NLVL];
    int unsigned tail [NLVL];
    int unsigned count [NLVL];
    logic [TICK_W-1:0] q_top, q_mid, q_bot;
    outcome_t outcome_q [$];
    int n_err, n_checked, n_add, n_full, n_disp, n_empty, n_done, n_requeue, n_lost, n_cfg;

    function new();
      foreach (head[i]) begin
        head[i] = 0;
        tail[i] = 0;
        count[i] = 0;
      end
      q_top = RESET_QUANTUM_TOP;
      q_mid = RESET_QUANTUM_MIDDLE;
      q_bot = RESET_QUANTUM_BOTTOM;
      n_err = 0; n_checked = 0; n_add = 0; n_full = 0; n_disp = 0;
      n_empty = 0; n_done = 0; n_requeue = 0; n_lost = 0; n_cfg = 0;
    endfunction

    function void set_quantum(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
      n_cfg++;
      case (idx)
        CFG_QUANTUM_TOP: q_top = val;
        CFG_QUANTUM_MIDDLE: q_mid = val;
        CFG_QUANTUM_BOTTOM: q_bot = val;
        default: ;
      endcase
    endfunction

    function logic [TICK_W-1:0] slice_for(int lvl);
      if (lvl >= NLVL - 1) return q_bot;
      if (lvl == 0) return q_top;
      return q_mid;
    endfunction

    function bit push(int lvl, logic [ENTRY_W-1:0] e);
      if (count[lvl] >= DEPTH) return 1'b0;
      slot[lvl][tail[lvl]] = e;
      tail[lvl] = (tail[lvl] + 1) % DEPTH;
      count[lvl]++;
      return 1'b1;
    endfunction

    function void accept_cmd(cmd_t c);
      outcome_t o;
      int lvl;
      int lvl_next;
      logic [ENTRY_W-1:0] e;
      logic [TICK_W-1:0] q;
      o = '0;
      if (c.is_dispatch == OP_ADD) begin
        n_add++;
        lvl = (c.level >= NLVL) ? NLVL - 1 : int'(c.level);
        if (!push(lvl, {c.proc_id, c.burst_time})) begin
          o.status = STATUS_FULL;
          n_full++;
        end
      end else begin
        n_disp++;
        lvl = 0;
        while (lvl < NLVL && count[lvl] == 0) lvl++;
        if (lvl == NLVL) begin
          o.status = STATUS_EMPTY;
          n_empty++;
        end else begin
          e = slot[lvl][head[lvl]];
          head[lvl] = (head[lvl] + 1) % DEPTH;
          count[lvl]--;
          q = slice_for(lvl);
          o.served_level = LVL_W'(lvl);
          o.served_id = e[ENTRY_W-1:TICK_W];
          if (q == 0 || e[TICK_W-1:0] <= q) begin
            o.ran_ticks = e[TICK_W-1:0];
            o.left_ticks = '0;
          end else begin
            o.ran_ticks = q;
            o.left_ticks = e[TICK_W-1:0] - q;
          end
          if (o.left_ticks == 0) begin
            o.finished = 1'b1;
            n_done++;
          end else begin
            lvl_next = (lvl < NLVL - 1) ? lvl + 1 : lvl;
            o.target_level = LVL_W'(lvl_next);
            if (!push(lvl_next, {o.served_id, o.left_ticks})) begin
              o.demote_dropped = 1'b1;
              n_lost++;
            end else begin
              n_requeue++;
            end
          end
        end
      end
      outcome_q.push_back(o);
    endfunction

    function string show(outcome_t o);
      return $sformatf("status=%0d lvl=%0d id=%0d ran=%0d left=%0d fin=%0d tgt=%0d lost=%0d",
                       o.status, o.served_level, o.served_id, o.ran_ticks, o.left_ticks,
                       o.finished, o.target_level, o.demote_dropped);
    endfunction

    function void match_outcome(outcome_t got);
      outcome_t want;
      string bad;
      if (outcome_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("[%0t] result with nothing pending: %s", $realtime, show(got));
        return;
      end
      want = outcome_q.pop_front();
      n_checked++;
      bad = "";
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.served_level !== want.served_level) bad = {bad, " served_level"};
      if (got.served_id !== want.served_id) bad = {bad, " served_id"};
      if (got.ran_ticks !== want.ran_ticks) bad = {bad, " ran_ticks"};
      if (got.left_ticks !== want.left_ticks) bad = {bad, " left_ticks"};
      if (got.finished !== want.finished) bad = {bad, " finished"};
      if (got.target_level !== want.target_level) bad = {bad, " target_level"};
      if (got.demote_dropped !== want.demote_dropped) bad = {bad, " demote_dropped"};
      if (bad != "") begin
        n_err++;
        if (n_err <= 10) begin
          $display("[%0t] result %0d differs in%s", $realtime, n_checked, bad);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic operation;
  logic [ID_W-1:0] proc_id;
  logic [TICK_W-1:0] burst_time;
  logic [LVL_W-1:0] add_level;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TICK_W-1:0] cfg_data;
  logic done;
  logic [STATUS_W-1:0] status;
  logic [LVL_W-1:0] served_level;
  logic [ID_W-1:0] served_id;
  logic [TICK_W-1:0] ran_ticks;
  logic [TICK_W-1:0] left_ticks;
  logic finished;
  logic [LVL_W-1:0] target_level;
  logic demote_dropped;

  sched_shadow shadow;
  int burst_left;
  int quiet;

  multilevel_feedback_queue_scheduler dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .proc_id(proc_id),
    .burst_time(burst_time),
    .add_level(add_level),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .status(status),
    .served_level(served_level),
    .served_id(served_id),
    .ran_ticks(ran_ticks),
    .left_ticks(left_ticks),
    .finished(finished),
    .target_level(target_level),
    .demote_dropped(demote_dropped)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        shadow.match_outcome('{status: status, served_level: served_level,
                               served_id: served_id, ran_ticks: ran_ticks,
                               left_ticks: left_ticks, finished: finished,
                               target_level: target_level,
                               demote_dropped: demote_dropped});
      end
      if (start && !busy) begin
        shadow.accept_cmd('{is_dispatch: operation, proc_id: proc_id,
                            burst_time: burst_time, level: add_level});
      end
      if (cfg_valid && cfg_ready) shadow.set_quantum(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == IDLE_LIMIT) begin
        $display("no handshake for %0d cycles", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_word(logic op, logic [ID_W-1:0] id, logic [TICK_W-1:0] ticks,
                           logic [LVL_W-1:0] lvl);
    @(negedge clk);
    start = 1'b1;
    operation = op;
    proc_id = id;
    burst_time = ticks;
    add_level = lvl;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic dispatch_word();
    send_word(OP_DISPATCH, ID_W'($urandom), TICK_W'($urandom), LVL_W'($urandom));
  endtask

  task automatic idle(int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 6));
    burst_left = $urandom_range(1, 12);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (shadow.pending() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_quantum(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [TICK_W-1:0] pick_burst();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return TICK_W'($urandom_range(0, 40));
      6, 7: return TICK_W'($urandom_range(0, 400));
      8: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return TICK_W'($urandom);
    endcase
  endfunction

  task automatic run_phase(logic [TICK_W-1:0] qt, logic [TICK_W-1:0] qm,
                           logic [TICK_W-1:0] qb, int add_pct, bit calm);
    int k;
    drain();
    write_quantum(CFG_QUANTUM_TOP, qt);
    write_quantum(CFG_QUANTUM_MIDDLE, qm);
    write_quantum(CFG_QUANTUM_BOTTOM, qb);
    write_quantum(CFG_SPARE, TICK_W'($urandom));
    burst_left = 0;
    for (k = 0; k < ITEMS_PER_PHASE; k++) begin
      if (!calm) pace();
      if ($urandom_range(0, 99) < add_pct) begin
        send_word(OP_ADD, ID_W'($urandom), pick_burst(), LVL_W'($urandom));
      end else begin
        dispatch_word();
      end
    end
  endtask

  initial begin
    shadow = new();
    rst = 1'b1;
    start = 1'b0;
    operation = OP_ADD;
    proc_id = '0;
    burst_time = '0;
    add_level = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_QUANTUM_TOP;
    cfg_data = '0;
    burst_left = 0;
    quiet = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    dispatch_word();
    send_word(OP_ADD, 8'h00, 16'd0, 2'd0);
    dispatch_word();
    send_word(OP_ADD, 8'hFF, 16'hFFFF, 2'd3);
    send_word(OP_ADD, 8'hAA, 16'd5, 2'd0);
    send_word(OP_ADD, 8'h55, 16'd6, 2'd0);
    send_word(OP_ADD, 8'h0F, 16'd11, 2'd1);
    send_word(OP_ADD, 8'hF0, 16'd16, 2'd2);
    idle(3);
    repeat (10) dispatch_word();
    send_word(OP_ADD, 8'h81, 16'h8000, 2'd1);
    dispatch_word();
    dispatch_word();
    dispatch_word();

    run_phase(16'd1, 16'd1, 16'd1, 75, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 40, 1'b0);
    run_phase(16'd0, 16'd0, 16'd0, 60, 1'b1);
    run_phase(16'd0, 16'd1, 16'hFFFF, 70, 1'b0);
    run_phase(16'd1, 16'hFFFF, 16'd0, 35, 1'b0);
    run_phase(TICK_W'($urandom), TICK_W'($urandom), TICK_W'($urandom), 55, 1'b0);
    run_phase(TICK_W'($urandom_range(1, 20)), TICK_W'($urandom_range(1, 20)),
              TICK_W'($urandom_range(1, 20)), 80, 1'b1);
    run_phase(TICK_W'($urandom_range(1, 60)), TICK_W'($urandom_range(1, 60)),
              TICK_W'($urandom_range(1, 60)), 30, 1'b0);
    run_phase(RESET_QUANTUM_TOP, RESET_QUANTUM_MIDDLE, RESET_QUANTUM_BOTTOM, 50, 1'b0);
    drain();
    repeat (10) @(posedge clk);

    $display("checked %0d results: %0d adds (%0d refused, queue full), %0d dispatches",
             shadow.n_checked, shadow.n_add, shadow.n_full, shadow.n_disp);
    $display("dispatch outcomes: %0d on empty, %0d finished, %0d requeued, %0d lost;",
             shadow.n_empty, shadow.n_done, shadow.n_requeue, shadow.n_lost);
    $display("%0d cfg writes", shadow.n_cfg);
    if (shadow.n_err == 0 && shadow.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results still pending", shadow.n_err, shadow.pending());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
